// ===== rtl/core/one_wire_bus_master_assert.svh =====
// Assertion macros for the 1-Wire bus master.
// Each property is sampled on the rising edge of clk and is disabled while rst_n is low.
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH
`ifndef SYNTHESIS
`define OWBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("one_wire_bus_master: same-cycle check failed");
`define OWBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("one_wire_bus_master: next-cycle check failed");
`else
`define OWBM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OWBM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/owbm_pkg.sv =====
package owbm_pkg;

  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_CFG    = 7;

  typedef logic [CMD_W-1:0]      cmd_t;
  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam cmd_t CMD_RESET = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;
  localparam cmd_t CMD_NONE  = 2'd3;

  localparam cfg_idx_t CFG_RESET_LOW     = 3'd0;
  localparam cfg_idx_t CFG_PRESENCE_WAIT = 3'd1;
  localparam cfg_idx_t CFG_RESET_TAIL    = 3'd2;
  localparam cfg_idx_t CFG_SLOT_LOW      = 3'd3;
  localparam cfg_idx_t CFG_WRITE_REST    = 3'd4;
  localparam cfg_idx_t CFG_READ_SAMPLE   = 3'd5;
  localparam cfg_idx_t CFG_READ_REST     = 3'd6;

  localparam cfg_data_t CFG_RESET_VAL [NUM_CFG] = '{
    10'd480, 10'd70, 10'd410, 10'd5, 10'd55, 10'd5, 10'd50
  };

endpackage

// ===== rtl/core/owbm_in_if.sv =====
interface owbm_in_if;
  logic             valid;
  logic             ready;
  logic             start_req;
  owbm_pkg::cmd_t   command;
  owbm_pkg::byte_t  tx_byte;
  logic             line_level;

  modport source (output valid, output start_req, output command, output tx_byte,
                  output line_level, input ready);
  modport sink   (input valid, input start_req, input command, input tx_byte,
                  input line_level, output ready);
endinterface

// ===== rtl/core/owbm_out_if.sv =====
interface owbm_out_if;
  logic            valid;
  logic            ready;
  logic            drive_low;
  logic            busy_res;
  logic            done_res;
  owbm_pkg::byte_t rx_byte;
  logic            presence_level;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output rx_byte, output presence_level, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input rx_byte, input presence_level, output ready);
endinterface

// ===== rtl/core/owbm_cfg_if.sv =====
interface owbm_cfg_if;
  logic                  valid;
  logic                  ready;
  owbm_pkg::cfg_idx_t    index;
  owbm_pkg::cfg_data_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/one_wire_bus_master.sv =====
// 1-Wire bus master for an open-drain line.
// in_bus carries one transaction per microsecond tick: an optional start request with
// its command (bus reset, write byte, read byte), the byte to send and the sampled
// line level. Every accepted tick yields exactly one transaction on out_bus: the line
// drive, busy, a one-tick done pulse, the last received byte and the presence level.
// cfg_bus writes the seven timing registers; it is always ready and writes take
// effect on the next tick. Indexes beyond the last register are dropped.
// The result of an accepted tick appears in the next cycle, and one tick is taken every
// cycle while the receiver keeps up: the whole phase update sits between the input
// handshake and the result register. in_bus.ready is high whenever the result register
// is empty or is being drained in the same cycle, so a stalled receiver holds its
// result and stops the tick stream until it takes it.
// Synchronous active-low reset returns the timing registers to their defaults, the
// sequencer to idle with the presence level at one, and empties the result register.
`include "one_wire_bus_master_assert.svh"

module one_wire_bus_master #(
  parameter int TIMER_BITS = 10
) (
  input  logic clk,
  input  logic rst_n,
  owbm_in_if.sink    in_bus,
  owbm_out_if.source out_bus,
  owbm_cfg_if.sink   cfg_bus
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_RLOW   = 3'd1;
  localparam logic [2:0] PH_RWAIT  = 3'd2;
  localparam logic [2:0] PH_RTAIL  = 3'd3;
  localparam logic [2:0] PH_SLOW   = 3'd4;
  localparam logic [2:0] PH_WREST  = 3'd5;
  localparam logic [2:0] PH_RDWAIT = 3'd6;
  localparam logic [2:0] PH_RDREST = 3'd7;

  localparam int LW = (TIMER_BITS > owbm_pkg::CFG_DATA_W) ? TIMER_BITS
                                                           : owbm_pkg::CFG_DATA_W;

  owbm_pkg::cfg_data_t cfg_r [owbm_pkg::NUM_CFG];

  logic [2:0]            phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [2:0]            slot_r, slot_nxt;
  owbm_pkg::cmd_t        op_r, op_nxt;
  owbm_pkg::byte_t       shift_r, shift_nxt;
  owbm_pkg::byte_t       rd_byte_r, rd_byte_nxt;
  logic                  pres_r, pres_nxt;
  logic                  done_nxt;
  logic                  drive_nxt;

  logic                  out_valid_r;
  logic                  out_drive_r;
  logic                  out_busy_r;
  logic                  out_done_r;
  owbm_pkg::byte_t       out_rx_r;
  logic                  out_pres_r;

  owbm_pkg::cfg_data_t   cfg_sel;
  logic [LW-1:0]         dur_ext;
  logic [TIMER_BITS-1:0] dur;
  logic [TIMER_BITS:0]   tick_cnt;
  logic                  in_fire;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < owbm_pkg::NUM_CFG; i++) begin
        cfg_r[i] <= owbm_pkg::CFG_RESET_VAL[i];
      end
    end else if (cfg_bus.valid && (cfg_bus.index < owbm_pkg::cfg_idx_t'(owbm_pkg::NUM_CFG))) begin
      cfg_r[cfg_bus.index] <= cfg_bus.data;
    end
  end

  // Duration of the current phase, with zero raised to one and clipped to the timer.
  always_comb begin
    unique case (phase_r)
      PH_RLOW:   cfg_sel = cfg_r[owbm_pkg::CFG_RESET_LOW];
      PH_RWAIT:  cfg_sel = cfg_r[owbm_pkg::CFG_PRESENCE_WAIT];
      PH_RTAIL:  cfg_sel = cfg_r[owbm_pkg::CFG_RESET_TAIL];
      PH_SLOW:   cfg_sel = cfg_r[owbm_pkg::CFG_SLOT_LOW];
      PH_WREST:  cfg_sel = cfg_r[owbm_pkg::CFG_WRITE_REST];
      PH_RDWAIT: cfg_sel = cfg_r[owbm_pkg::CFG_READ_SAMPLE];
      PH_IDLE, PH_RDREST: cfg_sel = cfg_r[owbm_pkg::CFG_READ_REST];
    endcase
    dur_ext = LW'(cfg_sel);
    if (dur_ext == '0) begin
      dur_ext = LW'(1);
    end
    if (dur_ext > LW'({TIMER_BITS{1'b1}})) begin
      dur_ext = LW'({TIMER_BITS{1'b1}});
    end
    dur = dur_ext[TIMER_BITS-1:0];
  end

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    slot_nxt    = slot_r;
    op_nxt      = op_r;
    shift_nxt   = shift_r;
    rd_byte_nxt = rd_byte_r;
    pres_nxt    = pres_r;
    done_nxt    = 1'b0;
    tick_cnt    = {1'b0, timer_r} + 1'b1;

    if (phase_r == PH_IDLE) begin
      if (in_bus.start_req && (in_bus.command != owbm_pkg::CMD_NONE)) begin
        op_nxt    = in_bus.command;
        timer_nxt = '0;
        slot_nxt  = '0;
        shift_nxt = (in_bus.command == owbm_pkg::CMD_WRITE) ? in_bus.tx_byte : '0;
        phase_nxt = (in_bus.command == owbm_pkg::CMD_RESET) ? PH_RLOW : PH_SLOW;
      end
    end else if (tick_cnt < {1'b0, dur}) begin
      timer_nxt = tick_cnt[TIMER_BITS-1:0];
    end else begin
      timer_nxt = '0;
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_RLOW: begin
          phase_nxt = PH_RWAIT;
        end
        PH_RWAIT: begin
          pres_nxt  = in_bus.line_level;
          phase_nxt = PH_RTAIL;
        end
        PH_RTAIL: begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
        PH_SLOW: begin
          phase_nxt = (op_r == owbm_pkg::CMD_READ) ? PH_RDWAIT : PH_WREST;
        end
        PH_WREST: begin
          shift_nxt = shift_r >> 1;
          slot_nxt  = slot_r + 3'd1;
          phase_nxt = (slot_nxt == 3'd0) ? PH_IDLE : PH_SLOW;
          done_nxt  = (slot_nxt == 3'd0);
        end
        PH_RDWAIT: begin
          shift_nxt = {in_bus.line_level, shift_r[7:1]};
          phase_nxt = PH_RDREST;
        end
        PH_RDREST: begin
          slot_nxt  = slot_r + 3'd1;
          phase_nxt = (slot_nxt == 3'd0) ? PH_IDLE : PH_SLOW;
          done_nxt  = (slot_nxt == 3'd0);
          if (slot_nxt == 3'd0) begin
            rd_byte_nxt = shift_r;
          end
        end
      endcase
    end

    drive_nxt = (phase_nxt == PH_RLOW) || (phase_nxt == PH_SLOW) ||
                ((phase_nxt == PH_WREST) && !shift_nxt[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      slot_r    <= '0;
      op_r      <= owbm_pkg::CMD_RESET;
      shift_r   <= '0;
      rd_byte_r <= '0;
      pres_r    <= 1'b1;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      slot_r    <= slot_nxt;
      op_r      <= op_nxt;
      shift_r   <= shift_nxt;
      rd_byte_r <= rd_byte_nxt;
      pres_r    <= pres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_drive_r <= drive_nxt;
      out_busy_r  <= (phase_nxt != PH_IDLE);
      out_done_r  <= done_nxt;
      out_rx_r    <= rd_byte_nxt;
      out_pres_r  <= pres_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.drive_low      = out_drive_r;
  assign out_bus.busy_res       = out_busy_r;
  assign out_bus.done_res       = out_done_r;
  assign out_bus.rx_byte        = out_rx_r;
  assign out_bus.presence_level = out_pres_r;

  // A completed operation is never reported while still busy, and the line is
  // only pulled low during an operation.
  `OWBM_ASSERT_IMP(a_done_not_busy, clk, rst_n, out_valid_r && out_done_r, !out_busy_r)
  `OWBM_ASSERT_IMP(a_drive_when_busy, clk, rst_n, out_valid_r && out_drive_r, out_busy_r)
  // The sequencer rests with the timer and slot counter cleared.
  `OWBM_ASSERT_IMP(a_idle_clean, clk, rst_n, phase_r == PH_IDLE,
                   (timer_r == '0) && (slot_r == 3'd0))
  // A reset command accepted while idle opens the reset low pulse.
  `OWBM_ASSERT_NXT(a_reset_start, clk, rst_n,
                   in_fire && (phase_r == PH_IDLE) && in_bus.start_req &&
                   (in_bus.command == owbm_pkg::CMD_RESET),
                   (phase_r == PH_RLOW) && out_valid_r && out_drive_r)

endmodule
